// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/mbs_pkg.sv -----
package mbs_pkg;

	// Sizes
	localparam int NUM_STACKS  = 4;
	localparam int STACK_DEPTH = 16;
	localparam int STORE_DEPTH = NUM_STACKS * STACK_DEPTH;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
	localparam int LIMIT_W     = 5;
	localparam int DATA_W      = 32;

	// Operation codes
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_LIST = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               operation;
		logic [1:0]               stack_index;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} rsp_t;

	// Controller -> datapath
	typedef struct packed {
		logic       latch_req;
		logic       push_commit;
		logic       pop_commit;
		logic       list_start;
		logic       list_next;
		logic       load_out;
		logic [1:0] out_status;
		logic       out_from_ram;
		logic       out_last;
	} mbs_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic [1:0] op;
		logic       exists;
		logic       full;
		logic       fill_zero;
		logic       list_last;
		logic       out_free;
	} mbs_sts_t;

endpackage

// ----- rtl/mbs_ram.sv -----
module mbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, registered read that holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mbs_datapath.sv -----
`include "assert_macros.svh"

module mbs_datapath import mbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  req_t               req,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	input  mbs_cmd_t           cmd,
	output mbs_sts_t           sts,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp
);

	req_t               req_q;
	logic [LIMIT_W-1:0] stack_limit_q;
	logic [FILL_W-1:0]  fill_q [NUM_STACKS];
	logic [FILL_W-1:0]  cnt_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic [FILL_W-1:0]  fill_cur;
	logic [FILL_W-1:0]  lim_eff;
	logic [FILL_W-1:0]  slot;
	logic [ADDR_W-1:0]  base;
	logic [ADDR_W-1:0]  addr;
	logic               ram_re;
	logic [DATA_W-1:0]  ram_rdata;
	logic               out_free;

	assign fill_cur = fill_q[req_q.stack_index];
	assign out_free = !rsp_valid_q || rsp_ready;

	// Limit clamped to 1..STACK_DEPTH
	always_comb begin
		priority if (stack_limit_q == '0) begin
			lim_eff = FILL_W'(1);
		end else if (int'(stack_limit_q) > STACK_DEPTH) begin
			lim_eff = FILL_W'(STACK_DEPTH);
		end else begin
			lim_eff = FILL_W'(stack_limit_q);
		end
	end

	// Slot within the selected stack
	always_comb begin
		priority if (cmd.push_commit) begin
			slot = fill_cur;
		end else if (cmd.pop_commit) begin
			slot = fill_cur - FILL_W'(1);
		end else if (cmd.list_next) begin
			slot = cnt_q + FILL_W'(1);
		end else begin
			slot = '0;
		end
	end

	assign base   = ADDR_W'(req_q.stack_index) * ADDR_W'(STACK_DEPTH);
	assign addr   = base + ADDR_W'(slot);
	assign ram_re = cmd.pop_commit || cmd.list_start || cmd.list_next;

	mbs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.push_commit),
		.waddr(addr),
		.wdata(req_q.value),
		.re   (ram_re),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	// Status to controller
	assign sts.op        = req_q.operation;
	assign sts.exists    = int'(req_q.stack_index) < NUM_STACKS;
	assign sts.full      = fill_cur >= lim_eff;
	assign sts.fill_zero = fill_cur == '0;
	assign sts.list_last = (cnt_q + FILL_W'(1)) == fill_cur;
	assign sts.out_free  = out_free;

	// Request latch and list cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.latch_req) begin
				req_q <= req;
			end
			if (cmd.list_start) begin
				cnt_q <= '0;
			end else if (cmd.list_next) begin
				cnt_q <= cnt_q + FILL_W'(1);
			end
		end
	end

	// Limit register and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_limit_q <= LIMIT_W'(16);
			for (int i = 0; i < NUM_STACKS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				stack_limit_q <= cfg_wdata;
			end
			if (cmd.push_commit) begin
				fill_q[req_q.stack_index] <= fill_cur + FILL_W'(1);
			end else if (cmd.pop_commit) begin
				fill_q[req_q.stack_index] <= fill_cur - FILL_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.status <= cmd.out_status;
			rsp_q.data   <= cmd.out_from_ram ? $signed(ram_rdata) : '0;
			rsp_q.last   <= cmd.out_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_CLK(a_load_needs_room, clk, arst_n, cmd.load_out |-> out_free,
		"result loaded over an unread result")
	`ASSERT_CLK(a_one_store_op, clk, arst_n,
		$onehot0({cmd.push_commit, cmd.pop_commit, cmd.list_start, cmd.list_next}),
		"more than one store operation at once")
	`ASSERT_CLK(a_fill_bound, clk, arst_n, int'(fill_cur) <= STACK_DEPTH,
		"fill count above stack depth")
	`ASSERT_CLK(a_push_grows, clk, arst_n,
		cmd.push_commit |=> fill_cur == $past(fill_cur) + FILL_W'(1),
		"push did not grow the stack by one")

endmodule

// ----- rtl/mbs_ctrl.sv -----
module mbs_ctrl import mbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  mbs_sts_t sts,
	output mbs_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_POP_WAIT,
		S_LIST_WAIT
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign req_ready = (state_q == S_IDLE);

	// Command decode and next state
	always_comb begin
		cmd           = '0;
		state_nxt     = state_q;
		cmd.out_last  = 1'b1;
		cmd.out_status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch_req = req_valid;
				if (req_valid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.op)
					OP_PUSH: begin
						if (sts.out_free) begin
							cmd.load_out = 1'b1;
							if (!sts.exists || sts.full) begin
								cmd.out_status = ST_FULL;
							end else begin
								cmd.push_commit = 1'b1;
							end
							state_nxt = S_IDLE;
						end
					end
					OP_POP, OP_LIST: begin
						if (!sts.exists || sts.fill_zero) begin
							if (sts.out_free) begin
								cmd.load_out   = 1'b1;
								cmd.out_status = ST_EMPTY;
								state_nxt      = S_IDLE;
							end
						end else if (sts.op == OP_POP) begin
							cmd.pop_commit = 1'b1;
							state_nxt      = S_POP_WAIT;
						end else begin
							cmd.list_start = 1'b1;
							state_nxt      = S_LIST_WAIT;
						end
					end
					OP_NONE: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_POP_WAIT: begin
				if (sts.out_free) begin
					cmd.load_out     = 1'b1;
					cmd.out_from_ram = 1'b1;
					state_nxt        = S_IDLE;
				end
			end
			S_LIST_WAIT: begin
				if (sts.out_free) begin
					cmd.load_out     = 1'b1;
					cmd.out_from_ram = 1'b1;
					cmd.out_last     = sts.list_last;
					if (sts.list_last) begin
						state_nxt = S_IDLE;
					end else begin
						cmd.list_next = 1'b1;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- rtl/multi_bounded_stack.sv -----
// Channel  Handshake              Payload
// req      req_valid/req_ready    req_t: operation, stack_index, value
// rsp      rsp_valid/rsp_ready    rsp_t: status, data, last
// cfg      cfg_we                 cfg_wdata: stack_limit
//
// Push, and any full or empty request: accept, then execute.
// Pop: accept, execute, then a wait for the registered read of the entry store.
// List: accept, execute, then one store read per listed entry.
// A full output register stalls the controller in place; a new request is
// taken while the last result still waits to be read.
// Reset clears fill counts and sets the limit to 16; the store is not cleared.
module multi_bounded_stack import mbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output rsp_t               rsp,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	mbs_cmd_t cmd;
	mbs_sts_t sts;

	mbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

// ----- verif/tb_multi_bounded_stack.sv -----
module tb_multi_bounded_stack;
	import mbs_pkg::*;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_t       req       = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_t       rsp;
	logic       cfg_we    = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	multi_bounded_stack i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stack model state
	logic signed [DATA_W-1:0] model_slots [NUM_STACKS][STACK_DEPTH];
	int   model_fill [NUM_STACKS];
	int   model_limit = 16;

	req_t pending_reqs [$];
	rsp_t expected_rsps [$];

	int   fail_count  = 0;
	int   req_count   = 0;
	int   rsp_count   = 0;
	int   full_count  = 0;
	int   empty_count = 0;
	int   cfg_count   = 0;
	int   hold_left   = 0;
	bit   no_idle     = 1'b0;

	// Expected responses for one accepted request
	task automatic predict_request(input req_t r);
		rsp_t e;
		int   sel;
		int   fill;
		int   lim;
		sel    = int'(r.stack_index);
		e      = '0;
		e.last = 1'b1;
		if (r.operation == OP_NONE)
			return;
		if (sel >= NUM_STACKS) begin
			e.status = (r.operation == OP_PUSH) ? ST_FULL : ST_EMPTY;
			expected_rsps.push_back(e);
			return;
		end
		fill = model_fill[sel];
		lim  = model_limit;
		if (lim < 1)
			lim = 1;
		if (lim > STACK_DEPTH)
			lim = STACK_DEPTH;
		if (r.operation == OP_PUSH) begin
			if (fill >= lim) begin
				e.status = ST_FULL;
			end else begin
				model_slots[sel][fill] = r.value;
				model_fill[sel]        = fill + 1;
				e.status               = ST_OK;
			end
			expected_rsps.push_back(e);
		end else if (fill == 0) begin
			e.status = ST_EMPTY;
			expected_rsps.push_back(e);
		end else if (r.operation == OP_POP) begin
			model_fill[sel] = fill - 1;
			e.status        = ST_OK;
			e.data          = model_slots[sel][fill-1];
			expected_rsps.push_back(e);
		end else begin
			for (int i = 0; i < fill; i++) begin
				e.status = ST_OK;
				e.data   = model_slots[sel][i];
				e.last   = (i == fill - 1);
				expected_rsps.push_back(e);
			end
		end
	endtask

	// Driver: offers queued requests, sometimes idles
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_request(req);
				req_count++;
			end
			if (!req_valid || req_ready) begin
				if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 9)) begin
					req       <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks responses, random stalls plus two long hold-offs
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_count++;
				if (rsp.status == ST_FULL)
					full_count++;
				if (rsp.status == ST_EMPTY)
					empty_count++;
				if (expected_rsps.size() == 0) begin
					$error("unexpected response status=%0d data=%h last=%0d",
						rsp.status, rsp.data, rsp.last);
					fail_count++;
				end else begin
					e = expected_rsps.pop_front();
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp.status);
						fail_count++;
					end
					if (rsp.data !== e.data) begin
						$error("data: expected %h, got %h", e.data, rsp.data);
						fail_count++;
					end
					if (rsp.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, rsp.last);
						fail_count++;
					end
				end
				if (rsp_count == 100 || rsp_count == 400)
					hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= no_idle || ($urandom_range(99) >= 9);
			end
		end
	end

	task automatic queue_req(input logic [1:0] op, input int idx, input logic [31:0] val);
		req_t r;
		r.operation   = op;
		r.stack_index = idx[1:0];
		r.value       = val;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(19))
			0: rand_word = 32'h7fff_ffff;
			1: rand_word = 32'h8000_0000;
			2: rand_word = 32'h0;
			3: rand_word = 32'hffff_ffff;
			default: rand_word = $urandom;
		endcase
	endfunction

	// Wait until nothing is in flight, then let a full list time pass
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (STACK_DEPTH + 8) @(posedge clk);
	endtask

	task automatic set_stack_limit(input int lim);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= lim[LIMIT_W-1:0];
		@(posedge clk);
		cfg_we      <= 1'b0;
		model_limit  = lim;
		cfg_count++;
	endtask

	// Random phase: mostly pushes and pops around a focus stack
	task automatic queue_random(input int n, input int push_pct);
		int   done;
		int   focus;
		int   idx;
		int   roll;
		done  = 0;
		focus = $urandom_range(NUM_STACKS - 1);
		while (done < n) begin
			idx  = ($urandom_range(99) < 55) ? focus : $urandom_range(3);
			roll = $urandom_range(99);
			if (roll < 4) begin
				queue_req(OP_NONE, idx, $urandom);
			end else begin
				if (roll < 4 + push_pct)
					queue_req(OP_PUSH, idx, rand_word());
				else if ($urandom_range(99) < 65)
					queue_req(OP_POP, idx, $urandom);
				else
					queue_req(OP_LIST, idx, $urandom);
				done++;
			end
		end
	endtask

	// Stimulus
	initial begin
		int limits [9];
		limits = '{31, 16, 2, 1, 17, 4, 0, 9, 16};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme values, one-entry pop, empty pop and list, unused operation
		queue_req(OP_PUSH, 0, 32'h7fff_ffff);
		queue_req(OP_PUSH, 1, 32'h8000_0000);
		queue_req(OP_PUSH, 2, 32'h0);
		queue_req(OP_PUSH, 3, 32'hffff_ffff);
		queue_req(OP_PUSH, 3, 32'h5a5a_5a5a);
		queue_req(OP_LIST, 3, 32'h0);
		queue_req(OP_LIST, 0, 32'hffff_ffff);
		queue_req(OP_POP,  0, 32'h0);
		queue_req(OP_POP,  0, 32'h0);
		queue_req(OP_LIST, 0, 32'h0);
		queue_req(OP_NONE, 1, 32'hdead_beef);
		queue_req(OP_POP,  1, 32'h0);
		queue_req(OP_PUSH, 1, 32'h1234_5678);

		// Zero limit acts as one; stack 3 now above its limit
		set_stack_limit(0);
		queue_req(OP_PUSH, 1, 32'h1);
		queue_req(OP_PUSH, 0, 32'hdead_beef);
		queue_req(OP_PUSH, 0, 32'h2);
		queue_req(OP_PUSH, 3, 32'h3);
		queue_req(OP_LIST, 3, 32'h0);
		queue_req(OP_POP,  3, 32'h0);
		queue_req(OP_PUSH, 3, 32'h4);
		queue_req(OP_POP,  3, 32'h0);
		queue_req(OP_PUSH, 3, 32'h7);

		// Random phases over a range of limits; one phase with no idling
		foreach (limits[p]) begin
			set_stack_limit(limits[p]);
			no_idle = (p == 1);
			queue_random(45, (limits[p] >= 9) ? 68 : 48);
		end

		wait_idle();
		no_idle = 1'b0;
		if (expected_rsps.size() != 0) begin
			$error("%0d responses never arrived", expected_rsps.size());
			fail_count++;
		end
		$display("Ran %0d requests over %0d stack_limit writes, checked %0d responses",
			req_count, cfg_count, rsp_count);
		$display("Responses included %0d full and %0d empty reports", full_count, empty_count);
		if (fail_count == 0)
			$display("PASS multi_bounded_stack");
		else
			$display("FAIL multi_bounded_stack");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("FAIL multi_bounded_stack");
		$finish;
	end

endmodule
